// ===== hw/rtl/sumc_pkg.sv =====
`default_nettype none
package sumc_pkg;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } op_e;

  localparam int unsigned NUM_CH = 4;

  // Channel numbers on the forward port
  localparam logic [2:0] CH_NONE  = 3'd0;
  localparam logic [2:0] CH_ONE   = 3'd1;
  localparam logic [2:0] CH_TWO   = 3'd2;
  localparam logic [2:0] CH_THREE = 3'd3;
  localparam logic [2:0] CH_FOUR  = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] CFG_COLOR_MODE = 3'd0;
  localparam logic [2:0] CFG_GAIN_ONE   = 3'd1;
  localparam logic [2:0] CFG_GAIN_TWO   = 3'd2;
  localparam logic [2:0] CFG_GAIN_THREE = 3'd3;
  localparam logic [2:0] CFG_GAIN_FOUR  = 3'd4;

  localparam logic [8:0] GAIN_UNITY = 9'd256;

  // Register map
  localparam logic [15:0] ADDR_CH1_LO    = 16'hFF10;
  localparam logic [15:0] ADDR_CH1_HI    = 16'hFF14;
  localparam logic [15:0] ADDR_CH2_HI    = 16'hFF19;
  localparam logic [15:0] ADDR_CH3_HI    = 16'hFF1E;
  localparam logic [15:0] ADDR_CH4_HI    = 16'hFF23;
  localparam logic [15:0] ADDR_CH1_LEN   = 16'hFF11;
  localparam logic [15:0] ADDR_CH2_LEN   = 16'hFF16;
  localparam logic [15:0] ADDR_CH3_LEN   = 16'hFF1B;
  localparam logic [15:0] ADDR_CH4_LEN   = 16'hFF20;
  localparam logic [15:0] ADDR_MASTER    = 16'hFF24;
  localparam logic [15:0] ADDR_PAN       = 16'hFF25;
  localparam logic [15:0] ADDR_POWER     = 16'hFF26;
  localparam logic [15:0] ADDR_UNUSED_LO = 16'hFF27;
  localparam logic [15:0] ADDR_UNUSED_HI = 16'hFF2F;
  localparam logic [15:0] ADDR_WAVE_LO   = 16'hFF30;
  localparam logic [15:0] ADDR_WAVE_HI   = 16'hFF3F;

  localparam logic [7:0] LEN_MASK    = 8'h3F;
  localparam logic [7:0] UNUSED_READ = 8'hFF;
  localparam logic [2:0] POWER_FILL  = 3'b111;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] address;
    logic [7:0]  wr_byte;
    logic [3:0]  level_one;
    logic [3:0]  level_two;
    logic [3:0]  level_three;
    logic [3:0]  level_four;
    logic [3:0]  active_flags;
    logic [7:0]  channel_read_data;
  } in_item_t;

  typedef struct packed {
    logic [7:0]         rd_byte;
    logic               length_strobe;
    logic               sweep_strobe;
    logic               envelope_strobe;
    logic [2:0]         phase_now;
    logic               sample_valid;
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
    logic [2:0]         forward_channel;
    logic               forward_write;
    logic [7:0]         forward_data;
    logic               power_off_pulse;
  } out_item_t;

  // Sequencer results for one item
  typedef struct packed {
    logic       length;
    logic       sweep;
    logic       envelope;
    logic       sample_fire;
    logic [2:0] phase_next;
  } seq_t;

  // Register decode results for one item
  typedef struct packed {
    logic [7:0] rd_byte;
    logic [2:0] fwd_ch;
    logic       fwd_wr;
    logic [7:0] fwd_data;
    logic       pwr_down;
    logic       phase_clr;
  } dec_t;

  function automatic logic [2:0] channel_of(input logic [15:0] a);
    logic [2:0] ch;
    ch = CH_NONE;
    if (a >= ADDR_CH1_LO && a <= ADDR_CH1_HI) ch = CH_ONE;
    else if (a > ADDR_CH1_HI && a <= ADDR_CH2_HI) ch = CH_TWO;
    else if (a > ADDR_CH2_HI && a <= ADDR_CH3_HI) ch = CH_THREE;
    else if (a > ADDR_CH3_HI && a <= ADDR_CH4_HI) ch = CH_FOUR;
    else if (a >= ADDR_WAVE_LO && a <= ADDR_WAVE_HI) ch = CH_THREE;
    return ch;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/sumc_ifs.sv =====
`default_nettype none
interface sumc_in_if;
  logic                valid;
  logic                ready;
  sumc_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sumc_out_if;
  logic                valid;
  logic                ready;
  sumc_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/sumc_seq.sv =====
`default_nettype none
module sumc_seq #(
  parameter int unsigned FRAME_PERIOD  = 8192,
  parameter int unsigned SAMPLE_PERIOD = 95
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         tick_i,
  input  wire logic         phase_clr_i,
  output sumc_pkg::seq_t    seq_o
);

  localparam int unsigned FW = $clog2(FRAME_PERIOD + 1);
  localparam int unsigned SW = $clog2(SAMPLE_PERIOD + 1);

  logic [FW-1:0] frame_q, frame_d;
  logic [SW-1:0] sample_q, sample_d;
  logic [2:0]    phase_q, phase_d;
  logic          frame_fire, sample_fire;

  assign frame_fire  = tick_i && (frame_q <= FW'(1));
  assign sample_fire = tick_i && (sample_q <= SW'(1));

  always_comb begin
    frame_d  = frame_q;
    sample_d = sample_q;
    phase_d  = phase_q;
    if (tick_i) begin
      frame_d  = frame_fire ? FW'(FRAME_PERIOD) : frame_q - FW'(1);
      sample_d = sample_fire ? SW'(SAMPLE_PERIOD) : sample_q - SW'(1);
      if (frame_fire) phase_d = phase_q + 3'd1;
    end
    if (phase_clr_i) phase_d = 3'd0;
  end

  assign seq_o.length      = frame_fire && !phase_q[0];
  assign seq_o.sweep       = frame_fire && (phase_q == 3'd2 || phase_q == 3'd6);
  assign seq_o.envelope    = frame_fire && (phase_q == 3'd7);
  assign seq_o.sample_fire = sample_fire;
  assign seq_o.phase_next  = phase_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q  <= FW'(FRAME_PERIOD);
      sample_q <= SW'(SAMPLE_PERIOD);
      phase_q  <= 3'd0;
    end else begin
      frame_q  <= frame_d;
      sample_q <= sample_d;
      phase_q  <= phase_d;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/sumc_mix.sv =====
`default_nettype none
module sumc_mix (
  input  wire logic [sumc_pkg::NUM_CH-1:0][3:0] level_i,
  input  wire logic [sumc_pkg::NUM_CH-1:0][8:0] gain_i,
  input  wire logic [3:0]                       pan_left_i,
  input  wire logic [3:0]                       pan_right_i,
  output logic signed [15:0]                    left_o,
  output logic signed [15:0]                    right_o
);

  logic [sumc_pkg::NUM_CH-1:0][12:0] prod;
  logic [5:0] sum_l, sum_r, off_l, off_r;

  always_comb begin
    sum_l = '0;
    sum_r = '0;
    for (int i = 0; i < sumc_pkg::NUM_CH; i++) begin
      prod[i] = 13'(level_i[i]) * 13'(gain_i[i]);
      // keep the Q8 integer part of each term
      if (pan_left_i[i])  sum_l = sum_l + 6'(prod[i][11:8]);
      if (pan_right_i[i]) sum_r = sum_r + 6'(prod[i][11:8]);
    end
    // remove the midpoint; the difference fits six signed bits
    off_l = sum_l - 6'd32;
    off_r = sum_r - 6'd32;
  end

  assign left_o  = {off_l, 10'd0};
  assign right_o = {off_r, 10'd0};

endmodule
`default_nettype wire

// ===== hw/rtl/sumc_regs.sv =====
`default_nettype none
module sumc_regs (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        step_i,
  input  wire logic [1:0]  op_i,
  input  wire logic [15:0] address_i,
  input  wire logic [7:0]  wr_byte_i,
  input  wire logic [3:0]  active_flags_i,
  input  wire logic [7:0]  channel_read_data_i,
  input  wire logic        color_mode_i,
  output sumc_pkg::dec_t   dec_o,
  output logic [3:0]       pan_left_o,
  output logic [3:0]       pan_right_o
);

  logic       powered_q, powered_d;
  logic       vin_l_q, vin_l_d, vin_r_q, vin_r_d;
  logic [2:0] master_l_q, master_l_d, master_r_q, master_r_d;
  logic [3:0] pan_l_q, pan_l_d, pan_r_q, pan_r_d;
  logic [2:0] ch;

  assign ch = sumc_pkg::channel_of(address_i);

  always_comb begin
    dec_o      = '0;
    powered_d  = powered_q;
    vin_l_d    = vin_l_q;
    vin_r_d    = vin_r_q;
    master_l_d = master_l_q;
    master_r_d = master_r_q;
    pan_l_d    = pan_l_q;
    pan_r_d    = pan_r_q;
    case (op_i)
      sumc_pkg::OP_READ: begin
        if (ch != sumc_pkg::CH_NONE) begin
          dec_o.fwd_ch  = ch;
          dec_o.rd_byte = channel_read_data_i;
        end else if (address_i == sumc_pkg::ADDR_MASTER) begin
          dec_o.rd_byte = {vin_l_q, master_l_q, vin_r_q, master_r_q};
        end else if (address_i == sumc_pkg::ADDR_PAN) begin
          dec_o.rd_byte = {pan_l_q, pan_r_q};
        end else if (address_i == sumc_pkg::ADDR_POWER) begin
          dec_o.rd_byte = {powered_q, sumc_pkg::POWER_FILL, active_flags_i};
        end else if (address_i >= sumc_pkg::ADDR_UNUSED_LO &&
                     address_i <= sumc_pkg::ADDR_UNUSED_HI) begin
          dec_o.rd_byte = sumc_pkg::UNUSED_READ;
        end
      end
      sumc_pkg::OP_WRITE: begin
        if (address_i == sumc_pkg::ADDR_POWER) begin
          powered_d = wr_byte_i[7];
          if (powered_q && !wr_byte_i[7]) begin
            dec_o.pwr_down = 1'b1;
            vin_l_d    = 1'b0;
            vin_r_d    = 1'b0;
            master_l_d = '0;
            master_r_d = '0;
            pan_l_d    = '0;
            pan_r_d    = '0;
          end else if (!powered_q && wr_byte_i[7]) begin
            dec_o.phase_clr = step_i;
          end
        end else if (address_i >= sumc_pkg::ADDR_WAVE_LO &&
                     address_i <= sumc_pkg::ADDR_WAVE_HI) begin
          // wave memory stays reachable while powered off
          dec_o.fwd_ch   = sumc_pkg::CH_THREE;
          dec_o.fwd_wr   = 1'b1;
          dec_o.fwd_data = wr_byte_i;
        end else if (!powered_q) begin
          if (!color_mode_i) begin
            if (address_i == sumc_pkg::ADDR_CH1_LEN) begin
              dec_o.fwd_ch   = sumc_pkg::CH_ONE;
              dec_o.fwd_wr   = 1'b1;
              dec_o.fwd_data = wr_byte_i & sumc_pkg::LEN_MASK;
            end else if (address_i == sumc_pkg::ADDR_CH2_LEN) begin
              dec_o.fwd_ch   = sumc_pkg::CH_TWO;
              dec_o.fwd_wr   = 1'b1;
              dec_o.fwd_data = wr_byte_i & sumc_pkg::LEN_MASK;
            end else if (address_i == sumc_pkg::ADDR_CH3_LEN) begin
              dec_o.fwd_ch   = sumc_pkg::CH_THREE;
              dec_o.fwd_wr   = 1'b1;
              dec_o.fwd_data = wr_byte_i;
            end else if (address_i == sumc_pkg::ADDR_CH4_LEN) begin
              dec_o.fwd_ch   = sumc_pkg::CH_FOUR;
              dec_o.fwd_wr   = 1'b1;
              dec_o.fwd_data = wr_byte_i & sumc_pkg::LEN_MASK;
            end
          end
        end else if (ch != sumc_pkg::CH_NONE) begin
          dec_o.fwd_ch   = ch;
          dec_o.fwd_wr   = 1'b1;
          dec_o.fwd_data = wr_byte_i;
        end else if (address_i == sumc_pkg::ADDR_MASTER) begin
          master_r_d = wr_byte_i[2:0];
          vin_r_d    = wr_byte_i[3];
          master_l_d = wr_byte_i[6:4];
          vin_l_d    = wr_byte_i[7];
        end else if (address_i == sumc_pkg::ADDR_PAN) begin
          pan_r_d = wr_byte_i[3:0];
          pan_l_d = wr_byte_i[7:4];
        end
      end
      default: begin
      end
    endcase
  end

  assign pan_left_o  = pan_l_q;
  assign pan_right_o = pan_r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      powered_q  <= 1'b0;
      vin_l_q    <= 1'b0;
      vin_r_q    <= 1'b0;
      master_l_q <= '0;
      master_r_q <= '0;
      pan_l_q    <= '0;
      pan_r_q    <= '0;
    end else if (step_i) begin
      powered_q  <= powered_d;
      vin_l_q    <= vin_l_d;
      vin_r_q    <= vin_r_d;
      master_l_q <= master_l_d;
      master_r_q <= master_r_d;
      pan_l_q    <= pan_l_d;
      pan_r_q    <= pan_r_d;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/sound_unit_sequencer_mixer_control.sv =====
`default_nettype none
// Sound unit control: frame sequencer, four-channel mixer and register decode.
// Each input item (tick, register read or register write) gives exactly one
// result item. An item is captured in an input register, decoded against the
// sound registers and sequencer state, and written to the output register
// once that register is free or being drained; one item is taken every cycle
// as long as the output side keeps taking results. Configuration (color mode,
// channel gains) is to be written by the user through the plain write port
// while no item is in flight; the block itself does not enforce this. Gains
// above unity saturate.
module sound_unit_sequencer_mixer_control #(
  parameter int unsigned FRAME_PERIOD  = 8192,
  parameter int unsigned SAMPLE_PERIOD = 95
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [2:0] cfg_idx_i,
  input  wire logic [8:0] cfg_wdata_i,
  sumc_in_if.sink         in_i,
  sumc_out_if.source      out_o
);

  logic                 s1_valid_q, s1_valid_d;
  sumc_pkg::in_item_t   s1_item_q;
  logic                 out_valid_q, out_valid_d;
  sumc_pkg::out_item_t  out_item_q, out_item_d;
  logic                 in_acc, step, is_tick;

  logic                 color_mode_q;
  logic [sumc_pkg::NUM_CH-1:0][8:0] gain_q;
  logic [8:0]           gain_sat;

  sumc_pkg::seq_t       seq;
  sumc_pkg::dec_t       dec;
  logic [3:0]           pan_l, pan_r;
  logic signed [15:0]   mix_l, mix_r;
  logic [sumc_pkg::NUM_CH-1:0][3:0] levels;

  // advance the decode stage when the output register is free or drains
  assign step        = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !s1_valid_q || step;
  assign in_acc      = in_i.valid && in_i.ready;
  assign s1_valid_d  = in_acc || (s1_valid_q && !step);
  assign out_valid_d = step || (out_valid_q && !out_o.ready);
  assign is_tick     = (s1_item_q.op == sumc_pkg::OP_TICK);

  assign levels = {s1_item_q.level_four, s1_item_q.level_three,
                   s1_item_q.level_two, s1_item_q.level_one};

  sumc_seq #(
    .FRAME_PERIOD (FRAME_PERIOD),
    .SAMPLE_PERIOD(SAMPLE_PERIOD)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tick_i     (step && is_tick),
    .phase_clr_i(dec.phase_clr),
    .seq_o      (seq)
  );

  sumc_regs u_regs (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .step_i             (step),
    .op_i               (s1_item_q.op),
    .address_i          (s1_item_q.address),
    .wr_byte_i          (s1_item_q.wr_byte),
    .active_flags_i     (s1_item_q.active_flags),
    .channel_read_data_i(s1_item_q.channel_read_data),
    .color_mode_i       (color_mode_q),
    .dec_o              (dec),
    .pan_left_o         (pan_l),
    .pan_right_o        (pan_r)
  );

  sumc_mix u_mix (
    .level_i    (levels),
    .gain_i     (gain_q),
    .pan_left_i (pan_l),
    .pan_right_i(pan_r),
    .left_o     (mix_l),
    .right_o    (mix_r)
  );

  always_comb begin
    out_item_d                 = '0;
    out_item_d.rd_byte         = dec.rd_byte;
    out_item_d.length_strobe   = seq.length;
    out_item_d.sweep_strobe    = seq.sweep;
    out_item_d.envelope_strobe = seq.envelope;
    out_item_d.phase_now       = seq.phase_next;
    out_item_d.sample_valid    = seq.sample_fire;
    out_item_d.left_sample     = seq.sample_fire ? mix_l : 16'sd0;
    out_item_d.right_sample    = seq.sample_fire ? mix_r : 16'sd0;
    out_item_d.forward_channel = dec.fwd_ch;
    out_item_d.forward_write   = dec.fwd_wr;
    out_item_d.forward_data    = dec.fwd_data;
    out_item_d.power_off_pulse = dec.pwr_down;
  end

  assign gain_sat = (cfg_wdata_i > sumc_pkg::GAIN_UNITY) ? sumc_pkg::GAIN_UNITY
                                                          : cfg_wdata_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_mode_q <= 1'b0;
      gain_q       <= {sumc_pkg::NUM_CH{sumc_pkg::GAIN_UNITY}};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sumc_pkg::CFG_COLOR_MODE: color_mode_q <= cfg_wdata_i[0];
        sumc_pkg::CFG_GAIN_ONE:   gain_q[0]    <= gain_sat;
        sumc_pkg::CFG_GAIN_TWO:   gain_q[1]    <= gain_sat;
        sumc_pkg::CFG_GAIN_THREE: gain_q[2]    <= gain_sat;
        sumc_pkg::CFG_GAIN_FOUR:  gain_q[3]    <= gain_sat;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) s1_item_q <= in_i.data;
    if (step) out_item_q <= out_item_d;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_item_q;

endmodule
`default_nettype wire

// ===== verif/sound_unit_sequencer_mixer_control_tb.sv =====
`timescale 1ns / 1ps

import sumc_pkg::*;

class sumc_scoreboard;
  localparam int unsigned FRAME_TICKS  = 8192;
  localparam int unsigned SAMPLE_TICKS = 95;

  // configuration copy
  bit         color_blocks;
  logic [8:0] gain [4];

  // sound unit state
  int unsigned frame_count;
  int unsigned sample_count;
  logic [2:0]  seq_phase;
  bit          powered;
  bit          vin_l, vin_r;
  logic [2:0]  master_l, master_r;
  logic [3:0]  pan_l, pan_r;

  out_item_t   pending_results[$];

  int unsigned mismatches;
  int unsigned checked;
  int unsigned ticks, reads, writes, samples;
  int unsigned len_strobes, sweep_strobes, env_strobes, pwr_downs;
  bit [7:0]    phase_mask;

  function new();
    color_blocks = 1'b0;
    foreach (gain[i]) gain[i] = GAIN_UNITY;
    frame_count  = FRAME_TICKS;
    sample_count = SAMPLE_TICKS;
    seq_phase    = '0;
    clear_sound_regs();
    phase_mask   = 8'b1;
  endfunction

  function void clear_sound_regs();
    powered  = 1'b0;
    vin_l    = 1'b0;
    vin_r    = 1'b0;
    master_l = '0;
    master_r = '0;
    pan_l    = '0;
    pan_r    = '0;
  endfunction

  function void set_cfg(logic [2:0] idx, logic [8:0] value);
    case (idx)
      CFG_COLOR_MODE: color_blocks = value[0];
      CFG_GAIN_ONE, CFG_GAIN_TWO, CFG_GAIN_THREE, CFG_GAIN_FOUR: begin
        // gains above unity saturate
        gain[idx - CFG_GAIN_ONE] = (value > GAIN_UNITY) ? GAIN_UNITY : value;
      end
      default: ;
    endcase
  endfunction

  function logic [2:0] mapped_channel(logic [15:0] a);
    if (a >= ADDR_WAVE_LO && a <= ADDR_WAVE_HI) return CH_THREE;
    if (a < ADDR_CH1_LO || a > ADDR_CH4_HI) return CH_NONE;
    if (a <= ADDR_CH1_HI) return CH_ONE;
    if (a <= ADDR_CH2_HI) return CH_TWO;
    if (a <= ADDR_CH3_HI) return CH_THREE;
    return CH_FOUR;
  endfunction

  function logic [15:0] mixed_side(in_item_t it, logic [3:0] pan);
    logic [3:0] lvl [4];
    int sum;
    int scaled;
    lvl[0] = it.level_one;
    lvl[1] = it.level_two;
    lvl[2] = it.level_three;
    lvl[3] = it.level_four;
    sum = 0;
    for (int i = 0; i < 4; i++) begin
      if (pan[i]) sum += (int'(lvl[i]) * int'(gain[i])) >> 8;
    end
    scaled = (sum - 32) * 1024;
    return scaled[15:0];
  endfunction

  function void note_item(in_item_t it);
    out_item_t  e;
    logic [2:0] ch;
    e  = '0;
    ch = mapped_channel(it.address);
    case (it.op)
      OP_TICK: begin
        ticks++;
        if (frame_count <= 1) begin
          frame_count       = FRAME_TICKS;
          e.length_strobe   = !seq_phase[0];
          e.sweep_strobe    = (seq_phase == 3'd2 || seq_phase == 3'd6);
          e.envelope_strobe = (seq_phase == 3'd7);
          seq_phase         = seq_phase + 3'd1;
        end else begin
          frame_count--;
        end
        if (sample_count <= 1) begin
          sample_count   = SAMPLE_TICKS;
          e.sample_valid = 1'b1;
          e.left_sample  = mixed_side(it, pan_l);
          e.right_sample = mixed_side(it, pan_r);
          samples++;
        end else begin
          sample_count--;
        end
      end
      OP_READ: begin
        reads++;
        if (ch != CH_NONE) begin
          e.forward_channel = ch;
          e.rd_byte         = it.channel_read_data;
        end else if (it.address == ADDR_MASTER) begin
          e.rd_byte = {vin_l, master_l, vin_r, master_r};
        end else if (it.address == ADDR_PAN) begin
          e.rd_byte = {pan_l, pan_r};
        end else if (it.address == ADDR_POWER) begin
          e.rd_byte = {powered, POWER_FILL, it.active_flags};
        end else if (it.address >= ADDR_UNUSED_LO && it.address <= ADDR_UNUSED_HI) begin
          e.rd_byte = UNUSED_READ;
        end
      end
      OP_WRITE: begin
        writes++;
        if (it.address == ADDR_POWER) begin
          if (powered && !it.wr_byte[7]) begin
            clear_sound_regs();
            e.power_off_pulse = 1'b1;
            pwr_downs++;
          end else if (!powered && it.wr_byte[7]) begin
            seq_phase = '0;
          end
          powered = it.wr_byte[7];
        end else if (it.address >= ADDR_WAVE_LO && it.address <= ADDR_WAVE_HI) begin
          e.forward_channel = CH_THREE;
          e.forward_write   = 1'b1;
          e.forward_data    = it.wr_byte;
        end else if (!powered) begin
          // apart from wave memory, only length loads pass while off, and none in color mode
          if (!color_blocks) begin
            case (it.address)
              ADDR_CH1_LEN: e.forward_channel = CH_ONE;
              ADDR_CH2_LEN: e.forward_channel = CH_TWO;
              ADDR_CH3_LEN: e.forward_channel = CH_THREE;
              ADDR_CH4_LEN: e.forward_channel = CH_FOUR;
              default: ;
            endcase
            if (e.forward_channel != CH_NONE) begin
              e.forward_write = 1'b1;
              e.forward_data  = (it.address == ADDR_CH3_LEN) ? it.wr_byte
                                                              : it.wr_byte & LEN_MASK;
            end
          end
        end else if (ch != CH_NONE) begin
          e.forward_channel = ch;
          e.forward_write   = 1'b1;
          e.forward_data    = it.wr_byte;
        end else if (it.address == ADDR_MASTER) begin
          {vin_l, master_l, vin_r, master_r} = it.wr_byte;
        end else if (it.address == ADDR_PAN) begin
          {pan_l, pan_r} = it.wr_byte;
        end
      end
      default: ;
    endcase
    e.phase_now = seq_phase;
    phase_mask[seq_phase] = 1'b1;
    len_strobes   += e.length_strobe;
    sweep_strobes += e.sweep_strobe;
    env_strobes   += e.envelope_strobe;
    pending_results.push_back(e);
  endfunction

  task flag_mismatch(string what);
    if (mismatches < 40) $display("MISMATCH at result %0d: %s", checked, what);
    mismatches++;
  endtask

  task compare_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want) flag_mismatch($sformatf("%s got 0x%h want 0x%h", name, got, want));
  endtask

  task check_result(out_item_t got);
    out_item_t want;
    checked++;
    if (pending_results.size() == 0) begin
      flag_mismatch("result with no item outstanding");
    end else begin
      want = pending_results.pop_front();
      compare_field("rd_byte", got.rd_byte, want.rd_byte);
      compare_field("length_strobe", got.length_strobe, want.length_strobe);
      compare_field("sweep_strobe", got.sweep_strobe, want.sweep_strobe);
      compare_field("envelope_strobe", got.envelope_strobe, want.envelope_strobe);
      compare_field("phase_now", got.phase_now, want.phase_now);
      compare_field("sample_valid", got.sample_valid, want.sample_valid);
      compare_field("left_sample", got.left_sample, want.left_sample);
      compare_field("right_sample", got.right_sample, want.right_sample);
      compare_field("forward_channel", got.forward_channel, want.forward_channel);
      compare_field("forward_write", got.forward_write, want.forward_write);
      compare_field("forward_data", got.forward_data, want.forward_data);
      compare_field("power_off_pulse", got.power_off_pulse, want.power_off_pulse);
    end
  endtask
endclass

module sound_unit_sequencer_mixer_control_tb;
  import sumc_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned FRAME_TICKS  = 8192;
  localparam int unsigned SAMPLE_TICKS = 95;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_RANDOM,
    RX_TOGGLE,
    RX_HOLD
  } rx_mode_e;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic [2:0] cfg_idx_i   = '0;
  logic [8:0] cfg_wdata_i = '0;

  sumc_in_if  in_bus ();
  sumc_out_if out_bus ();

  sumc_scoreboard sb;
  int unsigned    burst_left = 0;

  sound_unit_sequencer_mixer_control #(
    .FRAME_PERIOD (FRAME_TICKS),
    .SAMPLE_PERIOD(SAMPLE_TICKS)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_bus),
    .out_o      (out_bus)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_bus.valid && in_bus.ready) sb.note_item(in_bus.data);
      if (out_bus.valid && out_bus.ready) sb.check_result(out_bus.data);
    end
  end

  // receiver: open stretches, random stalls, toggling and holds
  initial begin
    rx_mode_e    rx_mode;
    int unsigned rx_left;
    out_bus.ready = 1'b0;
    rx_mode = RX_OPEN;
    rx_left = 0;
    forever begin
      @(negedge clk_i);
      if (rx_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        rx_left = (rx_mode == RX_HOLD) ? $urandom_range(2, 12) : $urandom_range(4, 60);
      end
      rx_left--;
      case (rx_mode)
        RX_OPEN:   out_bus.ready <= 1'b1;
        RX_RANDOM: out_bus.ready <= ($urandom_range(0, 9) < 7);
        RX_TOGGLE: out_bus.ready <= !out_bus.ready;
        default:   out_bus.ready <= (rx_left == 0);
      endcase
    end
  end

  initial begin
    #10_000_000;
    $display("[sound_unit_sequencer_mixer_control] ERROR");
    $finish;
  end

  function automatic in_item_t make_item(logic [1:0] op, logic [15:0] addr, logic [7:0] wd);
    in_item_t it;
    it.op                = op;
    it.address           = addr;
    it.wr_byte           = wd;
    it.level_one         = 4'($urandom);
    it.level_two         = 4'($urandom);
    it.level_three       = 4'($urandom);
    it.level_four        = 4'($urandom);
    it.active_flags      = 4'($urandom);
    it.channel_read_data = 8'($urandom);
    return it;
  endfunction

  function automatic in_item_t tick_item();
    in_item_t    it;
    int unsigned pick;
    it   = make_item(OP_TICK, 16'($urandom), 8'($urandom));
    pick = $urandom_range(0, 9);
    if (pick == 0) {it.level_one, it.level_two, it.level_three, it.level_four} = '1;
    else if (pick == 1) {it.level_one, it.level_two, it.level_three, it.level_four} = '0;
    return it;
  endfunction

  function automatic in_item_t random_access(bit allow_power);
    in_item_t    it;
    int unsigned pick;
    logic [15:0] addr;
    logic [1:0]  op;
    pick = $urandom_range(0, 99);
    if (pick < 80) begin
      addr = ADDR_CH1_LO + 16'($urandom_range(0, 47));
    end else if (pick < 92) begin
      case ($urandom_range(0, 6))
        0:       addr = ADDR_CH1_LEN;
        1:       addr = ADDR_CH2_LEN;
        2:       addr = ADDR_CH3_LEN;
        3:       addr = ADDR_CH4_LEN;
        4:       addr = ADDR_MASTER;
        5:       addr = ADDR_PAN;
        default: addr = ADDR_POWER;
      endcase
    end else begin
      addr = 16'($urandom);
    end
    pick = $urandom_range(0, 99);
    if (pick < 45) op = OP_TICK;
    else if (pick < 70) op = OP_READ;
    else if (pick < 97) op = OP_WRITE;
    else op = OP_UNUSED;
    it = make_item(op, addr, 8'($urandom));
    if (allow_power && $urandom_range(0, 24) == 0) begin
      it.op      = OP_WRITE;
      it.address = ADDR_POWER;
    end
    // keep power up where the sequencer must run through
    if (!allow_power && it.op == OP_WRITE && it.address == ADDR_POWER) it.wr_byte[7] = 1'b1;
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? 300 : $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        repeat ($urandom_range(1, 6)) begin
          @(negedge clk_i);
          in_bus.valid <= 1'b0;
        end
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_bus.valid <= 1'b1;
    in_bus.data  <= it;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
  endtask

  task automatic send_access(input logic [1:0] op, input logic [15:0] addr,
                             input logic [7:0] wd);
    send_item(make_item(op, addr, wd));
  endtask

  task automatic drain();
    int unsigned waited;
    @(negedge clk_i);
    in_bus.valid <= 1'b0;
    waited = 0;
    while (sb.pending_results.size() != 0 && waited < 5000) begin
      @(posedge clk_i);
      waited++;
    end
    if (sb.pending_results.size() != 0) begin
      sb.flag_mismatch($sformatf("%0d results never came", sb.pending_results.size()));
      sb.pending_results.delete();
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [2:0] idx, input logic [8:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_cfg(idx, value);
  endtask

  initial begin
    in_item_t    it;
    bit          color_plan [6];
    logic [8:0]  gain_plan [6][4];
    int unsigned soak;

    sb = new();
    in_bus.valid = 1'b0;
    in_bus.data  = '0;

    color_plan = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0};
    gain_plan  = '{'{9'd256, 9'd256, 9'd256, 9'd256},
                   '{9'd0, 9'd0, 9'd0, 9'd0},
                   '{9'd511, 9'd300, 9'd257, 9'd1},
                   '{9'd0, 9'd0, 9'd0, 9'd0},
                   '{9'd0, 9'd0, 9'd0, 9'd0},
                   '{9'd128, 9'd64, 9'd32, 9'd255}};
    for (int k = 3; k < 5; k++) begin
      for (int c = 0; c < 4; c++) gain_plan[k][c] = 9'($urandom);
    end
    color_plan[4] = 1'($urandom);

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: field extremes, powered-off rules, register map corners
    it = '1;
    it.op = OP_TICK;
    send_item(it);
    it = '0;
    send_item(it);
    send_access(OP_READ, ADDR_POWER, 8'h00);
    send_access(OP_WRITE, ADDR_MASTER, 8'hFF);
    send_access(OP_READ, ADDR_MASTER, 8'h00);
    send_access(OP_WRITE, ADDR_CH1_LEN, 8'hFF);
    send_access(OP_WRITE, ADDR_CH2_LEN, 8'hC5);
    send_access(OP_WRITE, ADDR_CH3_LEN, 8'hFF);
    send_access(OP_WRITE, ADDR_CH4_LEN, 8'hFF);
    send_access(OP_WRITE, ADDR_CH1_HI, 8'hFF);
    send_access(OP_WRITE, ADDR_WAVE_LO, 8'hA5);
    send_access(OP_READ, ADDR_WAVE_HI, 8'h00);
    send_access(OP_WRITE, ADDR_POWER, 8'h80);
    send_access(OP_WRITE, ADDR_MASTER, 8'hFF);
    send_access(OP_WRITE, ADDR_PAN, 8'hFF);
    send_access(OP_READ, ADDR_MASTER, 8'h00);
    send_access(OP_READ, ADDR_PAN, 8'h00);
    send_access(OP_READ, ADDR_POWER, 8'h00);
    send_access(OP_READ, ADDR_CH1_LO, 8'h00);
    send_access(OP_READ, ADDR_UNUSED_LO, 8'h00);
    send_access(OP_READ, ADDR_UNUSED_HI, 8'h00);
    send_access(OP_READ, 16'h0000, 8'h00);
    send_access(OP_WRITE, ADDR_CH4_HI, 8'h00);
    send_access(OP_WRITE, ADDR_WAVE_HI + 16'd1, 8'hFF);
    it = '1;
    it.op = OP_UNUSED;
    send_item(it);
    send_access(OP_WRITE, ADDR_POWER, 8'h00);
    send_access(OP_READ, ADDR_MASTER, 8'h00);
    send_access(OP_WRITE, ADDR_POWER, 8'h7F);
    send_access(OP_WRITE, ADDR_POWER, 8'hFF);

    // first three settings keep power up; the rest also toggle power
    for (int k = 0; k < 6; k++) begin
      drain();
      write_cfg(CFG_COLOR_MODE, {8'd0, color_plan[k]});
      write_cfg(CFG_GAIN_ONE, gain_plan[k][0]);
      write_cfg(CFG_GAIN_TWO, gain_plan[k][1]);
      write_cfg(CFG_GAIN_THREE, gain_plan[k][2]);
      write_cfg(CFG_GAIN_FOUR, gain_plan[k][3]);
      send_access(OP_WRITE, ADDR_PAN, (k == 0) ? 8'hFF : 8'($urandom));
      soak = (k < 3) ? 150 : 100;
      repeat (soak) begin
        if ($urandom_range(0, 399) == 0) begin
          send_access(OP_WRITE, $urandom_range(0, 1) ? ADDR_PAN : ADDR_MASTER, 8'($urandom));
        end
        send_item(tick_item());
      end
      repeat ((k < 3) ? 100 : 130) send_item(random_access(k >= 3));
    end

    drain();
    $display("Checked %0d results: %0d ticks, %0d reads, %0d writes, %0d mixed samples.",
             sb.checked, sb.ticks, sb.reads, sb.writes, sb.samples);
    $display("Phases seen %b; strobes length %0d sweep %0d envelope %0d; %0d power-offs.",
             sb.phase_mask, sb.len_strobes, sb.sweep_strobes, sb.env_strobes, sb.pwr_downs);
    if (sb.mismatches == 0) begin
      $display("[sound_unit_sequencer_mixer_control] OK");
    end else begin
      $display("[sound_unit_sequencer_mixer_control] ERROR");
    end
    $finish;
  end
endmodule
